// ===== rtl/wifd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wifd_pkg: shared types and constants
// Constants and the segment-close descriptor passed from front to back.
// ----------------------------------------------------------------------------
package wifd_pkg;

   localparam int NUM_SEGMENTS_DEF = 3;
   localparam int MAX_SEG_LEN_DEF  = 64;

   localparam int LEN_W   = 7;
   localparam int SCALE_W = 24;
   localparam int FEAT_W  = 16;
   localparam int SQ_W    = 38;
   localparam int SUM_W   = 22;
   localparam int TOT_W   = 48;
   localparam int DIST_W  = 32;

   localparam logic [2:0] REG_LEN0  = 3'd0;
   localparam logic [2:0] REG_LEN1  = 3'd1;
   localparam logic [2:0] REG_LEN2  = 3'd2;
   localparam logic [2:0] REG_MODE  = 3'd3;
   localparam logic [2:0] REG_SCL0  = 3'd4;
   localparam logic [2:0] REG_SCL1  = 3'd5;
   localparam logic [2:0] REG_SCL2  = 3'd6;

   // One closed segment handed to the back end.
   typedef struct packed {
      logic [SQ_W-1:0]    square_sum;
      logic [SUM_W-1:0]   min_sum;
      logic [SUM_W-1:0]   first_sum;
      logic               isect;
      logic [SCALE_W-1:0] scale;
      logic               last;
   } seg_type;

endpackage
`default_nettype wire

// ===== rtl/wifd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wifd_front: element accumulation
// Accepts element pairs, accumulates sums and closes segments into the queue.
// ----------------------------------------------------------------------------
module wifd_front #(
   parameter int NUM_SEGMENTS = wifd_pkg::NUM_SEGMENTS_DEF,
   parameter int MAX_SEG_LEN  = wifd_pkg::MAX_SEG_LEN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [wifd_pkg::FEAT_W-1:0]   req_feat_a,
   input  wire logic [wifd_pkg::FEAT_W-1:0]   req_feat_b,
   input  wire logic [wifd_pkg::LEN_W-1:0]    seg_len [3],
   input  wire logic [2:0]                    mode_mask,
   input  wire logic [wifd_pkg::SCALE_W-1:0]  scale [3],
   output logic                               seg_valid,
   input  wire logic                          seg_ready,
   output wifd_pkg::seg_type                  seg_data
);
   localparam int CNT_W = 8;
   localparam logic [CNT_W:0] MAXL = (CNT_W+1)'(MAX_SEG_LEN);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       segi_ff, segi_in;
   logic [wifd_pkg::SQ_W-1:0]  sq_ff, sq_in;
   logic [wifd_pkg::SUM_W-1:0] mn_ff, mn_in, fs_ff, fs_in;
   logic             out_v_ff, out_v_in;
   wifd_pkg::seg_type out_ff, out_in;

   logic [wifd_pkg::FEAT_W-1:0] d, mn;
   logic [31:0]      d2;
   logic [wifd_pkg::SQ_W:0]  sq_s;
   logic [wifd_pkg::SUM_W:0] mn_s, fs_s;
   logic [CNT_W-1:0] cnt_n;
   logic [CNT_W:0]   len;
   logic             close, last, acc;

   assign req_ready = !out_v_ff || seg_ready;
   assign acc       = req_valid && req_ready;
   assign seg_valid = out_v_ff;
   assign seg_data  = out_ff;

   always_comb begin
      d    = (req_feat_a >= req_feat_b) ? req_feat_a - req_feat_b : req_feat_b - req_feat_a;
      mn   = (req_feat_a <= req_feat_b) ? req_feat_a : req_feat_b;
      d2   = 32'(d) * 32'(d);
      sq_s = {1'b0, sq_ff} + (wifd_pkg::SQ_W+1)'(d2);
      mn_s = {1'b0, mn_ff} + (wifd_pkg::SUM_W+1)'(mn);
      fs_s = {1'b0, fs_ff} + (wifd_pkg::SUM_W+1)'(req_feat_a);
      cnt_n = count_ff + 1'b1;
      len  = (CNT_W+1)'(seg_len[segi_ff]);
      if (len == '0) len = (CNT_W+1)'(1);
      if (len > MAXL) len = MAXL;
      close = ({1'b0, cnt_n} >= len);
      last  = ({1'b0, segi_ff} + 3'd1) >= 3'(NUM_SEGMENTS);

      count_in = count_ff; segi_in = segi_ff;
      sq_in = sq_ff; mn_in = mn_ff; fs_in = fs_ff;
      out_v_in = out_v_ff && !seg_ready;
      out_in = out_ff;
      if (acc) begin
         sq_in = sq_s[wifd_pkg::SQ_W] ? '1 : sq_s[wifd_pkg::SQ_W-1:0];
         mn_in = mn_s[wifd_pkg::SUM_W] ? '1 : mn_s[wifd_pkg::SUM_W-1:0];
         fs_in = fs_s[wifd_pkg::SUM_W] ? '1 : fs_s[wifd_pkg::SUM_W-1:0];
         count_in = cnt_n;
         if (close) begin
            out_v_in = 1'b1;
            out_in.square_sum = sq_in;
            out_in.min_sum    = mn_in;
            out_in.first_sum  = fs_in;
            out_in.isect      = mode_mask[segi_ff];
            out_in.scale      = scale[segi_ff];
            out_in.last       = last;
            sq_in = '0; mn_in = '0; fs_in = '0; count_in = '0;
            segi_in = last ? 2'd0 : segi_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; segi_ff <= '0; sq_ff <= '0; mn_ff <= '0; fs_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         count_ff <= count_in; segi_ff <= segi_in; sq_ff <= sq_in;
         mn_ff <= mn_in; fs_ff <= fs_in; out_v_ff <= out_v_in;
      end
      out_ff <= out_in;
   end

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      32'(segi_ff) < NUM_SEGMENTS) else $error("segment index out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      seg_valid && !seg_ready |=> seg_valid && $stable(seg_data))
      else $error("segment dropped");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < MAXL) else $error("count beyond segment");
endmodule
`default_nettype wire

// ===== rtl/wifd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wifd_back: segment term evaluation
// Computes square root or quotient bit-serially, scales and accumulates.
// ----------------------------------------------------------------------------
module wifd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          seg_valid,
   output logic                               seg_ready,
   input  wifd_pkg::seg_type                  seg_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [wifd_pkg::DIST_W-1:0]        rsp_distance,
   output logic                               rsp_zero_sum_flag,
   output logic                               rsp_saturated
);
   localparam int RAD_W = wifd_pkg::SQ_W + 16;  // 54, root has 27 bits
   localparam int ROOT_W = RAD_W / 2;
   localparam int Q_W = wifd_pkg::SUM_W + 16;    // 38-bit quotient
   localparam int IT_W = 6;
   localparam int TERM_W = Q_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_ITER = 4'b0010, ST_MUL = 4'b0100, ST_ACC = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [IT_W-1:0]     it_ff, it_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;     // radicand or dividend bits
   logic [RAD_W/2+1:0]  rem_ff, rem_in;     // sqrt remainder
   logic [wifd_pkg::SUM_W:0] drem_ff, drem_in;  // division remainder
   logic [TERM_W-1:0]   res_ff, res_in;
   logic                isect_ff, isect_in, last_ff, last_in;
   logic [wifd_pkg::SUM_W-1:0] dvs_ff, dvs_in;
   logic [wifd_pkg::SCALE_W-1:0] scl_ff, scl_in;
   logic [TERM_W+wifd_pkg::SCALE_W-1:0] prod_ff, prod_in;
   logic [wifd_pkg::TOT_W-1:0] tot_ff, tot_in;
   logic [1:0]          flg_ff, flg_in;
   logic                rv_ff, rv_in, rz_ff, rz_in, rs_ff, rs_in;
   logic [wifd_pkg::DIST_W-1:0] rd_ff, rd_in;

   logic [wifd_pkg::SUM_W-1:0] diff;
   logic [RAD_W/2+1:0] trial, rem_sh;
   logic [wifd_pkg::SUM_W:0] dsh;
   logic [wifd_pkg::TOT_W:0] tsum;
   logic [TERM_W+wifd_pkg::SCALE_W-25:0] term;

   assign seg_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_distance = rd_ff;
   assign rsp_zero_sum_flag = rz_ff;
   assign rsp_saturated = rs_ff;

   always_comb begin
      state_in = state_ff; it_in = it_ff; rad_in = rad_ff; rem_in = rem_ff;
      drem_in = drem_ff; res_in = res_ff; isect_in = isect_ff; last_in = last_ff;
      dvs_in = dvs_ff; scl_in = scl_ff; prod_in = prod_ff; tot_in = tot_ff;
      flg_in = flg_ff; rv_in = rv_ff && !rsp_ready; rz_in = rz_ff; rs_in = rs_ff;
      rd_in = rd_ff;
      diff = '0; trial = '0; rem_sh = '0; dsh = '0; tsum = '0;
      term = prod_ff[TERM_W+wifd_pkg::SCALE_W-1:24];
      unique case (state_ff)
         ST_IDLE: begin
            if (seg_valid) begin
               isect_in = seg_data.isect; last_in = seg_data.last;
               scl_in = seg_data.scale; dvs_in = seg_data.first_sum;
               rem_in = '0; drem_in = '0; res_in = '0;
               if (seg_data.isect) begin
                  diff = (seg_data.first_sum >= seg_data.min_sum) ?
                         seg_data.first_sum - seg_data.min_sum :
                         seg_data.min_sum - seg_data.first_sum;
                  rad_in = RAD_W'({diff, 16'd0});
                  it_in = IT_W'(Q_W);
                  if (seg_data.first_sum == '0) begin
                     flg_in[0] = 1'b1;
                     it_in = '0;
                  end
               end else begin
                  rad_in = {seg_data.square_sum, 16'd0};
                  it_in = IT_W'(ROOT_W);
               end
               state_in = (it_in == '0) ? ST_MUL : ST_ITER;
            end
         end
         ST_ITER: begin
            if (isect_ff) begin
               // restoring division, one quotient bit per cycle
               dsh = {drem_ff[wifd_pkg::SUM_W-1:0], rad_ff[Q_W-1]};
               rad_in = {rad_ff[RAD_W-2:0], 1'b0};
               if (dsh >= {1'b0, dvs_ff}) begin
                  drem_in = dsh - {1'b0, dvs_ff};
                  res_in = {res_ff[TERM_W-2:0], 1'b1};
               end else begin
                  drem_in = dsh;
                  res_in = {res_ff[TERM_W-2:0], 1'b0};
               end
            end else begin
               // restoring square root, one root bit per cycle
               rem_sh = {rem_ff[RAD_W/2-1:0], rad_ff[RAD_W-1:RAD_W-2]};
               rad_in = {rad_ff[RAD_W-3:0], 2'b00};
               trial = {res_ff[RAD_W/2-1:0], 2'b01};
               if (rem_sh >= trial) begin
                  rem_in = rem_sh - trial;
                  res_in = {res_ff[TERM_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  res_in = {res_ff[TERM_W-2:0], 1'b0};
               end
            end
            it_in = it_ff - 1'b1;
            if (it_ff == IT_W'(1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = (TERM_W+wifd_pkg::SCALE_W)'(res_ff) *
                      (TERM_W+wifd_pkg::SCALE_W)'(scl_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            tsum = {1'b0, tot_ff} + (wifd_pkg::TOT_W+1)'(term);
            if (tsum[wifd_pkg::TOT_W]) begin
               flg_in[1] = 1'b1;
               tot_in = '1;
            end else begin
               tot_in = tsum[wifd_pkg::TOT_W-1:0];
            end
            state_in = ST_IDLE;
            if (last_ff) begin
               if (rv_ff && !rsp_ready) begin
                  state_in = ST_ACC;          // hold until the slot frees
                  tot_in = tot_ff; flg_in = flg_ff;
               end else begin
                  rv_in = 1'b1;
                  rz_in = flg_in[0];
                  if (tot_in[wifd_pkg::TOT_W-1:wifd_pkg::DIST_W] != '0) begin
                     rd_in = '1; rs_in = 1'b1;
                  end else begin
                     rd_in = tot_in[wifd_pkg::DIST_W-1:0]; rs_in = flg_in[1];
                  end
                  tot_in = '0; flg_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; tot_ff <= '0; flg_ff <= '0; rv_ff <= 1'b0;
         it_ff <= '0;
      end else begin
         state_ff <= state_in; tot_ff <= tot_in; flg_ff <= flg_in; rv_ff <= rv_in;
         it_ff <= it_in;
      end
      rad_ff <= rad_in; rem_ff <= rem_in; drem_ff <= drem_in; res_ff <= res_in;
      isect_ff <= isect_in; last_ff <= last_in; dvs_ff <= dvs_in; scl_ff <= scl_in;
      prod_ff <= prod_in; rz_ff <= rz_in; rs_ff <= rs_in; rd_ff <= rd_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("result lost");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance != '1 |-> !tot_ff[wifd_pkg::TOT_W-1] || !$rose(rsp_valid))
      else $error("saturation");
endmodule
`default_nettype wire

// ===== rtl/weighted_image_feature_distance_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_image_feature_distance_top: weighted feature distance
// Segmented intersection / Euclidean distance of two feature vectors.
// ----------------------------------------------------------------------------
// Element pairs are taken one a cycle by the front end while its one-entry
// output register is free or being taken. The front accumulates the squared
// difference, the minimum and the first-vector sum, and closes a segment when
// its configured length is reached, passing it to the back end through that
// register. The back end takes each segment, computes a 27-bit square root or
// a 38-bit quotient, one bit a cycle (no iteration for a zero sum), then scales
// and accumulates it, per segment; with short segments that unit sets the rate,
// otherwise requests flow at one a cycle unless the response is held back.
// One response follows the last element of the last segment.
// ----------------------------------------------------------------------------
module weighted_image_feature_distance_top #(
   parameter int NUM_SEGMENTS = wifd_pkg::NUM_SEGMENTS_DEF,
   parameter int MAX_SEG_LEN  = wifd_pkg::MAX_SEG_LEN_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_feat_a,
   input  wire logic [15:0] req_feat_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_distance,
   output logic             rsp_zero_sum_flag,
   output logic             rsp_saturated,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   logic [wifd_pkg::LEN_W-1:0]   len_ff [3];
   logic [2:0]                   mode_ff;
   logic [wifd_pkg::SCALE_W-1:0] scl_ff [3];
   logic                         seg_valid, seg_ready;
   wifd_pkg::seg_type            seg_data;

   assign csr_ready = 1'b1;

   // hold the register file; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff[0] <= 7'd3; len_ff[1] <= 7'd48; len_ff[2] <= 7'd15;
         mode_ff <= '0;
         scl_ff[0] <= 24'd5592400; scl_ff[1] <= 24'd93207; scl_ff[2] <= 24'd5592400;
      end else if (csr_valid) begin
         unique case (csr_index)
            wifd_pkg::REG_LEN0: len_ff[0] <= csr_data[6:0];
            wifd_pkg::REG_LEN1: len_ff[1] <= csr_data[6:0];
            wifd_pkg::REG_LEN2: len_ff[2] <= csr_data[6:0];
            wifd_pkg::REG_MODE: mode_ff   <= csr_data[2:0];
            wifd_pkg::REG_SCL0: scl_ff[0] <= csr_data;
            wifd_pkg::REG_SCL1: scl_ff[1] <= csr_data;
            wifd_pkg::REG_SCL2: scl_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   wifd_front #(.NUM_SEGMENTS(NUM_SEGMENTS), .MAX_SEG_LEN(MAX_SEG_LEN)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_feat_a, .req_feat_b,
      .seg_len(len_ff), .mode_mask(mode_ff), .scale(scl_ff),
      .seg_valid, .seg_ready, .seg_data
   );

   wifd_back u_back (
      .clock, .reset, .seg_valid, .seg_ready, .seg_data,
      .rsp_valid, .rsp_ready, .rsp_distance, .rsp_zero_sum_flag, .rsp_saturated
   );

   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == wifd_pkg::REG_MODE |=> mode_ff == $past(csr_data[2:0]))
      else $error("mode write lost");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      seg_valid && !seg_ready |-> !(req_valid && req_ready) || !$past(seg_valid))
      else $error("queue overrun");
   a_len: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == wifd_pkg::REG_LEN0 |=> len_ff[0] == $past(csr_data[6:0]))
      else $error("length write lost");
endmodule
`default_nettype wire

// ===== test/tb_weighted_image_feature_distance_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_image_feature_distance_top: self-checking bench for the distance
// Streams element-pair requests, predicts each weighted distance response
// in the bench and compares every field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_weighted_image_feature_distance_top;

   localparam int LIMIT = 20000;
   localparam logic [2:0] REG_NONE = 3'd7;    // no register at this index

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_feat_a = '0;
   logic [15:0] req_feat_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_distance;
   logic rsp_zero_sum_flag;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   weighted_image_feature_distance_top dut (.*);

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      logic [31:0] distance;
      logic        zero_sum;
      logic        saturated;
   } dist_type;

   // Predictor copy of the configuration and the running state.
   logic [6:0]  len_reg [3];
   logic [2:0]  mode_reg;
   logic [23:0] scale_reg [3];
   int unsigned elem_cnt, seg_idx;
   logic [63:0] sq_acc, min_acc, a_acc, tot_acc;
   logic [1:0]  flags;

   dist_type expected_dists[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  rsp_hold = 0;     // long hold-off of the receiver
   bit  rsp_busy = 0;

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] sat(logic [63:0] s, logic [63:0] lim);
      return (s > lim) ? lim : s;
   endfunction

   task automatic model_reset();
      len_reg = '{7'd3, 7'd48, 7'd15};
      mode_reg = 3'd0;
      scale_reg = '{24'd5592400, 24'd93207, 24'd5592400};
      elem_cnt = 0; seg_idx = 0;
      sq_acc = 0; min_acc = 0; a_acc = 0; tot_acc = 0; flags = 0;
   endtask

   // Advance the predictor by one element pair; queue a distance when due.
   task automatic predict_distance(logic [15:0] a, logic [15:0] b);
      logic [63:0] d, term, len, mx;
      logic [127:0] prod;
      dist_type r;
      d = (a >= b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
      mx = 64'd1 << 22;
      sq_acc  = sat(sq_acc + d * d, (64'd1 << 38) - 1);
      min_acc = sat(min_acc + ((a <= b) ? 64'(a) : 64'(b)), mx - 1);
      a_acc   = sat(a_acc + 64'(a), mx - 1);
      elem_cnt = (elem_cnt + 1) & 8'hFF;
      len = 64'(len_reg[seg_idx]);
      if (len == 0) len = 1;
      if (len > 64) len = 64;
      if (elem_cnt < len) return;
      if (mode_reg[seg_idx]) begin
         if (a_acc == 0) begin
            term = 0;
            flags[0] = 1'b1;
         end else begin
            d = (a_acc >= min_acc) ? a_acc - min_acc : min_acc - a_acc;
            term = (d << 16) / a_acc;
         end
      end else begin
         term = isqrt(sq_acc << 16);
      end
      prod = 128'(term) * 128'(scale_reg[seg_idx]);
      term = 64'(prod >> 24);
      if (tot_acc + term > (64'd1 << 48) - 1) flags[1] = 1'b1;
      tot_acc = sat(tot_acc + term, (64'd1 << 48) - 1);
      sq_acc = 0; min_acc = 0; a_acc = 0; elem_cnt = 0;
      seg_idx++;
      if (seg_idx < 3) return;
      r.zero_sum = flags[0];
      r.saturated = flags[1];
      if (tot_acc > 64'hFFFF_FFFF) begin
         r.distance = '1;
         r.saturated = 1'b1;
      end else begin
         r.distance = tot_acc[31:0];
      end
      expected_dists.push_back(r);
      tot_acc = 0; flags = 0; seg_idx = 0;
   endtask

   // Send one request after a random gap; hold it until accepted.
   // Valid stays up on return so that a request with no gap follows directly;
   // the next call or wait_drained drops it.
   task automatic send_pair(logic [15:0] a, logic [15:0] b, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_feat_a <= a;
      req_feat_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_distance(a, b);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_dists.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   // Write one register while idle, mirroring it in the predictor.
   // Valid stays up on return; the caller drops it after the last write.
   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         wifd_pkg::REG_LEN0, wifd_pkg::REG_LEN1, wifd_pkg::REG_LEN2:
            len_reg[idx] = val[6:0];
         wifd_pkg::REG_MODE: mode_reg = val[2:0];
         wifd_pkg::REG_SCL0, wifd_pkg::REG_SCL1, wifd_pkg::REG_SCL2:
            scale_reg[idx - wifd_pkg::REG_SCL0] = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(int l0, int l1, int l2, int m, int s0, int s1, int s2);
      write_reg(wifd_pkg::REG_LEN0, 24'(l0));
      write_reg(wifd_pkg::REG_LEN1, 24'(l1));
      write_reg(wifd_pkg::REG_LEN2, 24'(l2));
      write_reg(wifd_pkg::REG_MODE, 24'(m));
      write_reg(wifd_pkg::REG_SCL0, 24'(s0));
      write_reg(wifd_pkg::REG_SCL1, 24'(s1));
      write_reg(wifd_pkg::REG_SCL2, 24'(s2));
      csr_valid <= 1'b0;
   endtask

   // Reset values: 66 elements per vector pair.
   task automatic test_reset_config();
      repeat (2 * 66) send_pair(16'($urandom), 16'($urandom));
      wait_drained();
   endtask

   // Extremes of the fields, zero sums and both metrics.
   task automatic test_directed();
      set_config(1, 1, 1, 3'b111, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_pair(16'h0000, 16'h0000);      // zero sum in intersection
      send_pair(16'hFFFF, 16'h0000);
      send_pair(16'h0001, 16'hFFFF);
      wait_drained();
      set_config(1, 1, 1, 3'b000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_pair(16'hFFFF, 16'h0000);
      send_pair(16'h0000, 16'hFFFF);
      send_pair(16'hFFFF, 16'hFFFF);
      wait_drained();
      set_config(0, 0, 0, 3'b101, 0, 1, 24'h800000);  // length zero counts as one
      send_pair(16'h1234, 16'h0FFF);
      send_pair(16'h0000, 16'h00FF);
      send_pair(16'hAAAA, 16'h5555);
      wait_drained();
      // Lengths above the maximum clamp; big differences test saturation.
      set_config(127, 64, 100, 3'b010, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      repeat (192) send_pair(16'hFFFF, 16'h0000, 0);
      wait_drained();
      write_reg(REG_NONE, 24'h123456);    // unknown index: ignored
      csr_valid <= 1'b0;
   endtask

   // Random settings, mostly short segments, occasionally long ones.
   task automatic test_random();
      int n, l0, l1, l2;
      n = 0;
      while (n < 700) begin
         if ($urandom_range(0, 4) == 0) begin
            l0 = $urandom_range(1, 64); l1 = $urandom_range(1, 64);
            l2 = $urandom_range(1, 64);
         end else begin
            l0 = $urandom_range(0, 6); l1 = $urandom_range(0, 6);
            l2 = $urandom_range(0, 6);
         end
         set_config(l0, l1, l2, $urandom_range(0, 7), $urandom, $urandom,
                    ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : $urandom);
         repeat ($urandom_range(1, 4)) begin
            repeat ((l0 ? l0 : 1) + (l1 ? l1 : 1) + (l2 ? l2 : 1)) begin
               case ($urandom_range(0, 3))
                  0: send_pair(16'($urandom), 16'($urandom));
                  1: send_pair(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
                  2: send_pair(16'(16'hFFFF - $urandom_range(0, 3)),
                               16'($urandom_range(0, 3)));
                  default: send_pair(16'($urandom_range(0, 1) ? 0 : $urandom),
                                     16'($urandom));
               endcase
               n++;
            end
         end
         wait_drained();
      end
   endtask

   // Hold the receiver off while requests keep coming, to fill the block.
   task automatic test_backpressure();
      set_config(1, 1, 1, 3'b010, $urandom, $urandom, $urandom);
      rsp_hold = 1;
      repeat (60) send_pair(16'($urandom), 16'($urandom), 0);
      wait_drained();
   endtask

   // Receiver: random ready with stretches of none, and the long hold-off.
   initial begin
      int stall, held;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < 400) begin
               @(negedge clock);
               held++;
            end
            rsp_hold = 0;
         end
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Check each accepted response against the oldest predicted distance.
   always @(posedge clock) begin
      dist_type exp_d;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dists.size() == 0) begin
            $error("response with none expected: distance %h", rsp_distance);
            errors++;
         end else begin
            exp_d = expected_dists.pop_front();
            if (rsp_distance !== exp_d.distance) begin
               $error("distance: expected %h, got %h", exp_d.distance, rsp_distance);
               errors++;
            end
            if (rsp_zero_sum_flag !== exp_d.zero_sum) begin
               $error("zero_sum_flag: expected %b, got %b", exp_d.zero_sum,
                      rsp_zero_sum_flag);
               errors++;
            end
            if (rsp_saturated !== exp_d.saturated) begin
               $error("saturated: expected %b, got %b", exp_d.saturated, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("tb_weighted_image_feature_distance_top: FAIL");
         $finish;
      end
   end

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_config();
      test_directed();
      test_backpressure();
      test_random();
      wait_drained();
      if (errors == 0 && expected_dists.size() == 0)
         $display("tb_weighted_image_feature_distance_top: PASS");
      else
         $display("tb_weighted_image_feature_distance_top: FAIL");
      $finish;
   end

endmodule
